// ===== hdl/pcrc64_pkg.sv =====
// ----------------------------------------------------------------------------
// pcrc64_pkg: shared types, constants and functions of the CRC-64 engine
// Holds the register map, the queued operation and the bit-level CRC helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcrc64_pkg;

  localparam int CrcWidth   = 64;
  localparam int ByteWidth  = 8;
  localparam int CountWidth = 32;
  localparam int CfgIdxWidth = 3;

  localparam logic [CrcWidth-1:0]   PolyReset   = 64'h42F0_E1EB_A9EA_3693;
  localparam logic [CrcWidth-1:0]   InitReset   = '0;
  localparam logic [CrcWidth-1:0]   XorOutReset = '0;
  localparam logic [CountWidth-1:0] CountMax    = '1;

  // Configuration register indexes.
  typedef enum logic [CfgIdxWidth-1:0] {
    REG_POLYNOMIAL    = 3'd0,
    REG_INITIAL_VALUE = 3'd1,
    REG_XOR_OUT       = 3'd2,
    REG_REFLECT_IN    = 3'd3,
    REG_REFLECT_OUT   = 3'd4
  } cfg_reg_e;

  // Item kinds as carried in the input tuser bit.
  typedef enum logic {
    OP_ABSORB  = 1'b0,
    OP_RESTART = 1'b1
  } op_kind_e;

  // One classified item waiting in the queue.
  typedef struct packed {
    op_kind_e             kind;
    logic [ByteWidth-1:0] data;
  } op_t;

  // Settings the back end needs while it executes items.
  typedef struct packed {
    logic [CrcWidth-1:0] polynomial;
    logic [CrcWidth-1:0] initial_value;
    logic [CrcWidth-1:0] xor_out;
    logic                reflect_out;
  } crc_cfg_t;

  function automatic logic [ByteWidth-1:0] flip8(input logic [ByteWidth-1:0] b);
    logic [ByteWidth-1:0] r;
    for (int i = 0; i < ByteWidth; i++) begin
      r[i] = b[ByteWidth-1-i];
    end
    return r;
  endfunction

  function automatic logic [CrcWidth-1:0] flip64(input logic [CrcWidth-1:0] v);
    logic [CrcWidth-1:0] r;
    for (int i = 0; i < CrcWidth; i++) begin
      r[i] = v[CrcWidth-1-i];
    end
    return r;
  endfunction

  // Absorbs one byte MSB first: eight shift steps with conditional XOR.
  function automatic logic [CrcWidth-1:0] crc_step8(input logic [CrcWidth-1:0]  crc,
                                                     input logic [ByteWidth-1:0] din,
                                                     input logic [CrcWidth-1:0]  poly);
    logic [CrcWidth-1:0] r;
    r = crc ^ {din, {(CrcWidth-ByteWidth){1'b0}}};
    for (int i = 0; i < ByteWidth; i++) begin
      if (r[CrcWidth-1]) begin
        r = {r[CrcWidth-2:0], 1'b0} ^ poly;
      end else begin
        r = {r[CrcWidth-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/parametric_crc64_engine.sv =====
// ----------------------------------------------------------------------------
// parametric_crc64_engine: configurable 64-bit CRC with reflection and final XOR
// Pipeline: two register stages, the queue and the output register; an accepted
// item goes from the queue to the output register, held there until taken.
// Throughput: one byte per cycle without stalls; the byte fold is combinational.
// Reset (rst, synchronous) restores the default polynomial and register values,
// clears the CRC register to the initial value, zeroes the count, and empties
// the queue and output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// The engine follows the usual parameterized CRC model. Each input transaction
// either absorbs a message byte (tuser low) or restarts the computation
// (tuser high). Every transaction produces one output transaction with the
// finished CRC and the number of bytes absorbed since the last restart; the
// count saturates at its maximum while the CRC keeps absorbing.
//
// The front end accepts transactions, reflects the byte if reflect_in is set
// and parks the item in a two-entry queue. The back end pops one item per
// cycle whenever its output register is free or being drained, so input and
// output stall independently without loss of rate.
//
// Configuration writes are accepted every cycle and take effect at once; they
// do not touch the CRC register or the count. Indexes beyond the register map
// are ignored.

module parametric_crc64_engine (
  input  logic                                clk,
  input  logic                                rst,
  // Item input
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [pcrc64_pkg::ByteWidth-1:0]    s_axis_tdata,  // [7:0] data_byte
  input  logic                                s_axis_tuser,  // [0] opcode
  // Result output
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [63:0] crc_value, [95:64] byte_count
  output logic [pcrc64_pkg::CrcWidth+pcrc64_pkg::CountWidth-1:0] m_axis_tdata,
  // Configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pcrc64_pkg::CfgIdxWidth-1:0]  cfg_index,
  input  logic [pcrc64_pkg::CrcWidth-1:0]     cfg_data
);
  import pcrc64_pkg::*;

  crc_cfg_t crc_cfg;
  logic     reflect_in;
  logic     q_valid;
  logic     q_ready;
  op_t      q_op;

  // The register file never stalls a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_cfg.polynomial    <= PolyReset;
      crc_cfg.initial_value <= InitReset;
      crc_cfg.xor_out       <= XorOutReset;
      crc_cfg.reflect_out   <= 1'b0;
      reflect_in            <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_e'(cfg_index))
        REG_POLYNOMIAL:    crc_cfg.polynomial    <= cfg_data;
        REG_INITIAL_VALUE: crc_cfg.initial_value <= cfg_data;
        REG_XOR_OUT:       crc_cfg.xor_out       <= cfg_data;
        REG_REFLECT_IN:    reflect_in            <= cfg_data[0];
        REG_REFLECT_OUT:   crc_cfg.reflect_out   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  pcrc64_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .reflect_in    (reflect_in),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_op          (q_op)
  );

  pcrc64_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (crc_cfg),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_op          (q_op),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== hdl/pcrc64_front.sv =====
// ----------------------------------------------------------------------------
// pcrc64_front: input side of the CRC-64 engine
// Accepts items, applies input reflection, and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcrc64_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [pcrc64_pkg::ByteWidth-1:0] s_axis_tdata,  // [7:0] data_byte
  input  logic                            s_axis_tuser,  // [0] opcode
  input  logic                            reflect_in,
  output logic                            q_valid,
  input  logic                            q_ready,
  output pcrc64_pkg::op_t                 q_op
);
  import pcrc64_pkg::*;

  op_t        entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  op_t        op_in;

  assign s_axis_tready = (count != 2'd2);
  assign q_valid       = (count != 2'd0);
  assign q_op          = entry[rd_ptr];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = q_valid && q_ready;

  // Classify the item and put the byte in MSB-first order.
  always_comb begin
    op_in.kind = op_kind_e'(s_axis_tuser);
    op_in.data = reflect_in ? flip8(s_axis_tdata) : s_axis_tdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= op_in;
    end
  end

endmodule

// ===== hdl/pcrc64_back.sv =====
// ----------------------------------------------------------------------------
// pcrc64_back: execution side of the CRC-64 engine
// Updates the CRC register and byte count and registers each finished result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcrc64_back (
  input  logic                                clk,
  input  logic                                rst,
  input  pcrc64_pkg::crc_cfg_t                cfg,
  input  logic                                q_valid,
  output logic                                q_ready,
  input  pcrc64_pkg::op_t                     q_op,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [63:0] crc_value, [95:64] byte_count
  output logic [pcrc64_pkg::CrcWidth+pcrc64_pkg::CountWidth-1:0] m_axis_tdata
);
  import pcrc64_pkg::*;

  logic [CrcWidth-1:0]   crc_register;
  logic [CrcWidth-1:0]   crc_register_next;
  logic [CountWidth-1:0] bytes_absorbed;
  logic [CountWidth-1:0] bytes_absorbed_next;
  logic [CrcWidth-1:0]   crc_finished;
  logic                  take;

  assign q_ready = !m_axis_tvalid || m_axis_tready;
  assign take    = q_valid && q_ready;

  always_comb begin
    case (q_op.kind)
      OP_RESTART: begin
        crc_register_next   = cfg.initial_value;
        bytes_absorbed_next = '0;
      end
      OP_ABSORB: begin
        crc_register_next   = crc_step8(crc_register, q_op.data, cfg.polynomial);
        bytes_absorbed_next = (bytes_absorbed == CountMax) ? bytes_absorbed
                                                           : bytes_absorbed + 32'd1;
      end
      default: begin
        crc_register_next   = crc_register;
        bytes_absorbed_next = bytes_absorbed;
      end
    endcase
    crc_finished = (cfg.reflect_out ? flip64(crc_register_next) : crc_register_next)
                   ^ cfg.xor_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_register   <= InitReset;
      bytes_absorbed <= '0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (take) begin
        crc_register   <= crc_register_next;
        bytes_absorbed <= bytes_absorbed_next;
        m_axis_tvalid  <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_axis_tdata <= {bytes_absorbed_next, crc_finished};
    end
  end

endmodule

// ===== sim/tb_parametric_crc64_engine.sv =====
// ----------------------------------------------------------------------------
// tb_parametric_crc64_engine: self-checking bench for the CRC-64 engine
// Streams absorb and restart transactions through the engine under several
// register settings and traffic patterns. A cycle-free predictor computes the
// finished CRC and byte count for each accepted transaction, and every output
// transaction is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_parametric_crc64_engine;

  import pcrc64_pkg::*;

  // Number of quiet cycles (no transaction on any channel) that ends the run.
  // Even with both sides throttled, a quiet stretch of that length is far
  // beyond anything a working engine produces.
  localparam int QuietLimit          = 2000;
  localparam int RandomPhases        = 8;
  localparam int ItemsPerPhase       = 125;
  localparam int DrainCycles         = 8;
  localparam int FirstUnmappedIndex  = 5;
  localparam int LastIndex           = (1 << CfgIdxWidth) - 1;

  // Traffic patterns, cycled through by the random phases.
  localparam int TrafficSmooth       = 0;
  localparam int TrafficSenderGaps   = 1;
  localparam int TrafficReceiverSlow = 2;
  localparam int TrafficBothThrottle = 3;

  typedef struct packed {
    logic [CrcWidth-1:0]   crc;
    logic [CountWidth-1:0] count;
  } crc_result_t;

  // Clock, reset and every engine input start at a known value.
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [ByteWidth-1:0]  s_axis_tdata  = '0;   // [7:0] data_byte
  logic                  s_axis_tuser  = 1'b0; // [0] opcode

  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [63:0] crc_value, [95:64] byte_count
  logic [CrcWidth+CountWidth-1:0] m_axis_tdata;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CfgIdxWidth-1:0] cfg_index = '0;
  logic [CrcWidth-1:0]    cfg_data  = '0;

  parametric_crc64_engine uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  // Predictor copy of the register file, starting from the reset values.
  logic [CrcWidth-1:0]   poly_setting     = PolyReset;
  logic [CrcWidth-1:0]   init_setting     = InitReset;
  logic [CrcWidth-1:0]   xorout_setting   = XorOutReset;
  logic                  refl_in_setting  = 1'b0;
  logic                  refl_out_setting = 1'b0;

  // Predictor copy of the running state.
  logic [CrcWidth-1:0]   crc_state   = InitReset;
  logic [CountWidth-1:0] count_state = '0;

  op_t         pending_items[$];
  crc_result_t crc_expected[$];
  op_t         item_in_flight;

  int sender_gap_pct     = 0;
  int receiver_stall_pct = 0;
  int error_count        = 0;
  int quiet_cycles       = 0;

  // Advances the predictor by one transaction and returns what the engine
  // should report for it. The bit loops mirror the byte and the register by
  // index so that no package helper is reused for the prediction.
  function automatic crc_result_t advance_crc(input op_t item);
    crc_result_t          res;
    logic [ByteWidth-1:0] msg_byte;
    logic [CrcWidth-1:0]  shown;
    logic                 carry;
    if (item.kind == OP_RESTART) begin
      crc_state   = init_setting;
      count_state = '0;
    end else begin
      if (count_state != CountMax) begin
        count_state = count_state + 1'b1;
      end
      msg_byte = item.data;
      if (refl_in_setting) begin
        for (int i = 0; i < ByteWidth; i++) begin
          msg_byte[i] = item.data[ByteWidth-1-i];
        end
      end
      crc_state[CrcWidth-1 -: ByteWidth] = crc_state[CrcWidth-1 -: ByteWidth] ^ msg_byte;
      for (int s = 0; s < ByteWidth; s++) begin
        carry     = crc_state[CrcWidth-1];
        crc_state = crc_state << 1;
        if (carry) begin
          crc_state = crc_state ^ poly_setting;
        end
      end
    end
    shown = crc_state;
    if (refl_out_setting) begin
      for (int i = 0; i < CrcWidth; i++) begin
        shown[i] = crc_state[CrcWidth-1-i];
      end
    end
    res.crc   = shown ^ xorout_setting;
    res.count = count_state;
    return res;
  endfunction

  // Driver: when the input slot is free it either offers the next pending
  // item or leaves a gap, at the rate the current traffic pattern asks for.
  // tvalid is assigned once per edge, so back-to-back items keep it high.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        crc_expected.push_back(advance_crc(item_in_flight));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= sender_gap_pct) begin
          item_in_flight = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= item_in_flight.data;
          s_axis_tuser  <= item_in_flight.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted result against the oldest prediction and
  // throttles tready according to the current traffic pattern.
  always @(posedge clk) begin
    crc_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (crc_expected.size() == 0) begin
          $error("unexpected result transaction: crc_value %h byte_count %h",
                 m_axis_tdata[CrcWidth-1:0], m_axis_tdata[CrcWidth +: CountWidth]);
          error_count++;
        end else begin
          want = crc_expected.pop_front();
          if (m_axis_tdata[CrcWidth-1:0] !== want.crc) begin
            $error("crc_value: expected %h, got %h", want.crc, m_axis_tdata[CrcWidth-1:0]);
            error_count++;
          end
          if (m_axis_tdata[CrcWidth +: CountWidth] !== want.count) begin
            $error("byte_count: expected %h, got %h", want.count,
                   m_axis_tdata[CrcWidth +: CountWidth]);
            error_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Progress counter: any transaction on any channel clears it.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("Some tests failed");
    $finish;
  end

  // Waits until every queued item has gone in and every result has come out.
  task automatic wait_idle();
    while (pending_items.size() != 0 || s_axis_tvalid || crc_expected.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Writes one register and mirrors the write into the predictor once the
  // handshake completes. cfg_valid is left high; the caller lowers it after
  // the last write so that it gets a single assignment per edge.
  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [CrcWidth-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    case (idx)
      REG_POLYNOMIAL:    poly_setting     = val;
      REG_INITIAL_VALUE: init_setting     = val;
      REG_XOR_OUT:       xorout_setting   = val;
      REG_REFLECT_IN:    refl_in_setting  = val[0];
      REG_REFLECT_OUT:   refl_out_setting = val[0];
      default: ;
    endcase
  endtask

  // Writes the whole register map plus one write to an unmapped index, which
  // the engine must ignore.
  task automatic program_engine(input logic [CrcWidth-1:0] poly, input logic [CrcWidth-1:0] init,
                                input logic [CrcWidth-1:0] xo, input logic [CrcWidth-1:0] rin,
                                input logic [CrcWidth-1:0] rout);
    write_reg(REG_POLYNOMIAL, poly);
    write_reg(REG_INITIAL_VALUE, init);
    write_reg(REG_XOR_OUT, xo);
    write_reg(REG_REFLECT_IN, rin);
    write_reg(REG_REFLECT_OUT, rout);
    write_reg(CfgIdxWidth'($urandom_range(LastIndex, FirstUnmappedIndex)),
              {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_item(input op_kind_e kind, input logic [ByteWidth-1:0] data);
    op_t item;
    item.kind = kind;
    item.data = data;
    pending_items.push_back(item);
  endtask

  // A 64-bit register value that leans toward the extremes and the default.
  function automatic logic [CrcWidth-1:0] pick_word();
    case ($urandom_range(4))
      0:       return '0;
      1:       return '1;
      2:       return PolyReset;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    logic [ByteWidth-1:0] check_msg[9];
    check_msg = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part, first under the reset register values: a restart with
    // a nonzero byte (the byte must be ignored), the byte extremes, single
    // set bits at either end, and the usual nine-character check message.
    queue_item(OP_RESTART, 8'hC3);
    queue_item(OP_ABSORB, 8'h00);
    queue_item(OP_ABSORB, 8'hFF);
    queue_item(OP_ABSORB, 8'h80);
    queue_item(OP_ABSORB, 8'h01);
    queue_item(OP_RESTART, 8'h00);
    foreach (check_msg[i]) begin
      queue_item(OP_ABSORB, check_msg[i]);
    end
    wait_idle();

    // All-ones registers with both reflections on. The reflect registers get
    // all 64 bits set, so only bit 0 may count. No restart comes first: a
    // register write must leave the running CRC and count alone.
    program_engine('1, '1, '1, '1, '1);
    queue_item(OP_ABSORB, 8'hFF);
    queue_item(OP_ABSORB, 8'h00);
    queue_item(OP_ABSORB, 8'hA5);
    queue_item(OP_RESTART, 8'hFF);
    queue_item(OP_ABSORB, 8'h5A);
    queue_item(OP_ABSORB, 8'h01);
    wait_idle();

    // Random phases. Each reprograms the engine while it is idle and then
    // streams random bytes with occasional restarts under one traffic
    // pattern. The first one clears every register, with the reflect writes
    // carrying set upper bits that must be masked off. Count saturation
    // needs four billion bytes and is out of reach in a run of this length.
    for (int p = 0; p < RandomPhases; p++) begin
      sender_gap_pct     = 0;
      receiver_stall_pct = 0;
      if (p == 0) begin
        program_engine('0, '0, '0, {{(CrcWidth-1){1'b1}}, 1'b0}, {{(CrcWidth-1){1'b1}}, 1'b0});
      end else begin
        program_engine(pick_word(), pick_word(), pick_word(), {$urandom, $urandom},
                       {$urandom, $urandom});
      end
      case (p % 4)
        TrafficSenderGaps:   sender_gap_pct = 73;
        TrafficReceiverSlow: receiver_stall_pct = 73;
        TrafficBothThrottle: begin
          sender_gap_pct     = 33;
          receiver_stall_pct = 33;
        end
        default: ;
      endcase
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if ($urandom_range(9) == 0) begin
          queue_item(OP_RESTART, ByteWidth'($urandom));
        end else begin
          queue_item(OP_ABSORB, ByteWidth'($urandom));
        end
      end
      wait_idle();
    end

    // Let any stray result surface before the verdict.
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
